[rtl/core/csump_pkg.sv]
// csump_pkg: types and constants of the carrier-status use-mask parser
// no dependencies; used by the channel interface, the record walker, the top level and the checker

package csump_pkg;

   localparam int unsigned MASK_W   = 16;
   localparam int unsigned WORD_W   = 16;
   localparam int unsigned COUNT_W  = 18;

   localparam int unsigned CARRIER_BASE = 1;
   localparam int unsigned SKIP_WORDS   = 3;
   localparam int unsigned BRANCH_WORDS = 4;

   typedef enum logic [8:0] {
      PH_IDLE   = 9'b000000001,
      PH_CARNO  = 9'b000000010,
      PH_SKIP   = 9'b000000100,
      PH_BRCNT  = 9'b000001000,
      PH_BRWD   = 9'b000010000,
      PH_ALMCNT = 9'b000100000,
      PH_ALMWD  = 9'b001000000,
      PH_CRDCNT = 9'b010000000,
      PH_CRDWD  = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              start_req;
   } req_payload_type;

   typedef struct packed {
      logic [MASK_W-1:0] use_mask;
      logic              bad_carrier;
   } rsp_payload_type;

   typedef struct packed {
      logic              done;
      logic [MASK_W-1:0] use_mask;
      logic              bad_carrier;
   } walk_result_type;

endpackage

[rtl/core/csump_chan_if.sv]
// csump_chan_if: valid/ready channel carrying one payload per transaction
// payload type is given by the instantiating scope; depends on csump_pkg for its default

interface csump_chan_if #(
   parameter type payload_type = csump_pkg::req_payload_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/csump_walker.sv]
// csump_walker: phase state machine and counters that walk the carrier records
// depends on csump_pkg; stepped once per transaction by the top level

module csump_walker #(
   parameter int unsigned MAX_CARRIERS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [csump_pkg::WORD_W-1:0]  word,
   input  logic                          start_req,
   output csump_pkg::walk_result_type    result
);

   localparam int unsigned BitIdxW = $clog2(csump_pkg::MASK_W);
   localparam logic [csump_pkg::WORD_W-1:0] MaxCarrier = csump_pkg::WORD_W'(MAX_CARRIERS);
   localparam logic [csump_pkg::WORD_W-1:0] MaskTop    = csump_pkg::WORD_W'(csump_pkg::MASK_W);
   localparam logic [csump_pkg::WORD_W-1:0] CarrierBase =
      csump_pkg::WORD_W'(csump_pkg::CARRIER_BASE);
   localparam logic [csump_pkg::WORD_W-1:0] One        = csump_pkg::WORD_W'(1);
   localparam logic [csump_pkg::COUNT_W-1:0] CountOne  = csump_pkg::COUNT_W'(1);

   csump_pkg::phase_type                phase_ff, phase_in;
   logic [csump_pkg::WORD_W-1:0]        carriers_ff, carriers_in;
   logic [csump_pkg::COUNT_W-1:0]       words_ff, words_in;
   logic [csump_pkg::MASK_W-1:0]        mask_ff, mask_in;
   logic                                bad_ff, bad_in;
   logic                                done;
   logic [BitIdxW-1:0]                  bit_idx;

   assign bit_idx = BitIdxW'(word - CarrierBase);

   always_comb begin
      phase_in    = phase_ff;
      carriers_in = carriers_ff;
      words_in    = words_ff;
      mask_in     = mask_ff;
      bad_in      = bad_ff;
      done        = 1'b0;
      if (step) begin
         if (start_req) begin
            mask_in     = '0;
            bad_in      = 1'b0;
            words_in    = '0;
            carriers_in = word;
            if (word == '0) begin
               phase_in = csump_pkg::PH_IDLE;
               done     = 1'b1;
            end else begin
               phase_in = csump_pkg::PH_CARNO;
            end
         end else begin
            unique case (phase_ff)
               csump_pkg::PH_CARNO: begin
                  if (word == '0 || word > MaxCarrier) begin
                     bad_in = 1'b1;
                  end else if (word <= MaskTop) begin
                     mask_in = mask_ff | (csump_pkg::MASK_W'(1) << bit_idx);
                  end
                  words_in = csump_pkg::COUNT_W'(csump_pkg::SKIP_WORDS);
                  phase_in = csump_pkg::PH_SKIP;
               end
               csump_pkg::PH_SKIP: begin
                  words_in = words_ff - CountOne;
                  if (words_ff == CountOne) phase_in = csump_pkg::PH_BRCNT;
               end
               csump_pkg::PH_BRCNT: begin
                  words_in = csump_pkg::COUNT_W'(word)
                           * csump_pkg::COUNT_W'(csump_pkg::BRANCH_WORDS);
                  phase_in = (word == '0) ? csump_pkg::PH_ALMCNT : csump_pkg::PH_BRWD;
               end
               csump_pkg::PH_BRWD: begin
                  words_in = words_ff - CountOne;
                  if (words_ff == CountOne) phase_in = csump_pkg::PH_ALMCNT;
               end
               csump_pkg::PH_ALMCNT: begin
                  words_in = csump_pkg::COUNT_W'(word);
                  phase_in = (word == '0) ? csump_pkg::PH_CRDCNT : csump_pkg::PH_ALMWD;
               end
               csump_pkg::PH_ALMWD: begin
                  words_in = words_ff - CountOne;
                  if (words_ff == CountOne) phase_in = csump_pkg::PH_CRDCNT;
               end
               csump_pkg::PH_CRDCNT: begin
                  words_in = csump_pkg::COUNT_W'(word);
                  if (word == '0) begin
                     carriers_in = carriers_ff - One;
                     done        = (carriers_ff == One);
                     phase_in    = done ? csump_pkg::PH_IDLE : csump_pkg::PH_CARNO;
                  end else begin
                     phase_in = csump_pkg::PH_CRDWD;
                  end
               end
               csump_pkg::PH_CRDWD: begin
                  words_in = words_ff - CountOne;
                  if (words_ff == CountOne) begin
                     carriers_in = carriers_ff - One;
                     done        = (carriers_ff == One);
                     phase_in    = done ? csump_pkg::PH_IDLE : csump_pkg::PH_CARNO;
                  end
               end
               default: begin
                  phase_in = csump_pkg::PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= csump_pkg::PH_IDLE;
         carriers_ff <= '0;
         words_ff    <= '0;
         mask_ff     <= '0;
         bad_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         carriers_ff <= carriers_in;
         words_ff    <= words_in;
         mask_ff     <= mask_in;
         bad_ff      <= bad_in;
      end
   end

   assign result = '{done: done, use_mask: mask_in, bad_carrier: bad_in};

endmodule

[rtl/core/carrier_status_use_mask_parser.sv]
// carrier_status_use_mask_parser: top level with input register, record walker, result buffer
// depends on csump_pkg, csump_chan_if and csump_walker

// Takes one message word per transaction and accepts a new word every cycle unless the result
// buffer is full and not being drained. Each accepted word is held in an input register and
// then updates the record walker, so a result is offered on rsp_if once the word that completes
// the message (the last card word or a zero card count of the last record, or a start word
// with a carrier count of zero) has gone through the input register into the result buffer.
// Results go into a two-entry buffer; words keep flowing while one result waits, and
// req_if.ready drops only when both entries are full and the downstream side is not taking
// one. A start word aborts any message in progress, which then gives no result.

module carrier_status_use_mask_parser #(
   parameter int unsigned MAX_CARRIERS = 16
) (
   input  logic          clock,
   input  logic          reset,
   csump_chan_if.sink    req_if,
   csump_chan_if.source  rsp_if
);

   logic                               in_valid_ff;
   logic [csump_pkg::WORD_W-1:0]       in_word_ff;
   logic                               in_start_ff;
   logic                               advance;
   logic                               push, pop;
   logic [1:0]                         count_ff, count_in;
   logic                               wr_ptr_ff, rd_ptr_ff;
   csump_pkg::rsp_payload_type         buf_ff [2];
   csump_pkg::walk_result_type         walk;

   assign pop     = rsp_if.valid && rsp_if.ready;
   assign advance = in_valid_ff && (count_ff != 2'd2 || pop);
   assign push    = advance && walk.done;
   assign req_if.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_word_ff  <= req_if.payload.word;
         in_start_ff <= req_if.payload.start_req;
      end
   end

   csump_walker #(
      .MAX_CARRIERS (MAX_CARRIERS)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .word      (in_word_ff),
      .start_req (in_start_ff),
      .result    (walk)
   );

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff].use_mask    <= walk.use_mask;
         buf_ff[wr_ptr_ff].bad_carrier <= walk.bad_carrier;
      end
   end

   assign rsp_if.valid   = (count_ff != 2'd0);
   assign rsp_if.payload = buf_ff[rd_ptr_ff];

endmodule

[rtl/core/csump_checker.sv]
// csump_checker: port-level assertions for carrier_status_use_mask_parser
// depends on csump_pkg widths; attached to the top level by the bind below

module csump_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [csump_pkg::WORD_W-1:0] req_word,
   input logic                         req_start,
   input logic                         rsp_valid,
   input logic                         rsp_ready
);

   // a pending result is held until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before its transaction");

   // reset leaves no result pending
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // with the result buffer empty the input is never stalled
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result buffer");

   // a zero carrier count accepted with no result pending is answered by a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_start && req_word == '0 && !rsp_valid
      |-> ##2 rsp_valid)
      else $error("zero carrier count gave no result");

endmodule

bind carrier_status_use_mask_parser csump_checker u_csump_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_word  (req_if.payload.word),
   .req_start (req_if.payload.start_req),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready)
);
